>>> sv/sitbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitbd_pkg
// Shared types, constants and the reciprocal table for the base converter.
// ----------------------------------------------------------------------------
package sitbd_pkg;

  localparam int ALPHA_SIZE = 32;
  localparam int IDX_W      = $clog2(ALPHA_SIZE);
  localparam int CHAR_W     = 8;
  localparam int ALPHA_W    = ALPHA_SIZE * CHAR_W;
  localparam int LEN_W      = 6;
  localparam int MAG_W      = 32;
  localparam int CODE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_MID_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_MID_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH    = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_MIN   = 8'd33;
  localparam logic [CHAR_W-1:0] CHAR_MAX   = 8'd126;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // floor(2^32 / len)
  function automatic logic [MAG_W-1:0] recip(input logic [LEN_W-1:0] len);
    logic [MAG_W-1:0] r;
    case (len)
      6'd2:    r = 32'h80000000;
      6'd3:    r = 32'h55555555;
      6'd4:    r = 32'h40000000;
      6'd5:    r = 32'h33333333;
      6'd6:    r = 32'h2AAAAAAA;
      6'd7:    r = 32'h24924924;
      6'd8:    r = 32'h20000000;
      6'd9:    r = 32'h1C71C71C;
      6'd10:   r = 32'h19999999;
      6'd11:   r = 32'h1745D174;
      6'd12:   r = 32'h15555555;
      6'd13:   r = 32'h13B13B13;
      6'd14:   r = 32'h12492492;
      6'd15:   r = 32'h11111111;
      6'd16:   r = 32'h10000000;
      6'd17:   r = 32'h0F0F0F0F;
      6'd18:   r = 32'h0E38E38E;
      6'd19:   r = 32'h0D79435E;
      6'd20:   r = 32'h0CCCCCCC;
      6'd21:   r = 32'h0C30C30C;
      6'd22:   r = 32'h0BA2E8BA;
      6'd23:   r = 32'h0B21642C;
      6'd24:   r = 32'h0AAAAAAA;
      6'd25:   r = 32'h0A3D70A3;
      6'd26:   r = 32'h09D89D89;
      6'd27:   r = 32'h097B425E;
      6'd28:   r = 32'h09249249;
      6'd29:   r = 32'h08D3DCB0;
      6'd30:   r = 32'h08888888;
      6'd31:   r = 32'h08421084;
      6'd32:   r = 32'h08000000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/sitbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitbd_front
// Alphabet check after reset or a register write; accepts words, splits sign
// and magnitude, and queues them when the alphabet is good.
// ----------------------------------------------------------------------------
module sitbd_front #(
  parameter int MAX_BASE = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [sitbd_pkg::LEN_W-1:0]           base_length,
  input  logic [sitbd_pkg::ALPHA_W-1:0]         alphabet,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sitbd_pkg::MAG_W-1:0]    value,
  input  sitbd_pkg::queue_status_t              q_status,
  output logic                                  push,
  output sitbd_pkg::item_t                      push_item
);
  import sitbd_pkg::*;

  logic             busy;
  logic             bad;
  logic             ok;
  logic [IDX_W-1:0] idx;

  logic [CHAR_W-1:0] cur;
  logic              in_use;
  logic              bad_char;
  logic              dup;
  logic              step_bad;
  logic              len_ok;
  logic [MAG_W-1:0]  raw;

  always_comb begin
    cur      = alphabet[{idx, 3'b000} +: CHAR_W];
    in_use   = {1'b0, idx} < base_length;
    bad_char = (cur < CHAR_MIN) || (cur > CHAR_MAX) || (cur == CHAR_PLUS) ||
               (cur == CHAR_MINUS);
    dup = 1'b0;
    for (int j = 0; j < ALPHA_SIZE; j++) begin
      if ((LEN_W'(j) > {1'b0, idx}) && (LEN_W'(j) < base_length) &&
          (alphabet[j*CHAR_W +: CHAR_W] == cur)) begin
        dup = 1'b1;
      end
    end
    step_bad = in_use && (bad_char || dup);
    len_ok   = (base_length >= LEN_W'(2)) && (base_length <= LEN_W'(MAX_BASE));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      busy <= 1'b1;
      bad  <= 1'b0;
      ok   <= 1'b0;
      idx  <= '0;
    end else if (busy) begin
      bad <= bad | step_bad;
      idx <= idx + IDX_W'(1);
      if (idx == IDX_W'(ALPHA_SIZE - 1)) begin
        busy <= 1'b0;
        ok   <= !(bad | step_bad) && len_ok;
      end
    end
  end

  assign raw            = value;
  assign in_ready       = !busy && !q_status.full;
  assign push           = in_valid && in_ready && ok;
  assign push_item.neg  = raw[MAG_W-1];
  assign push_item.mag  = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;

endmodule

>>> sv/sitbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitbd_queue
// Short word queue between the front and the digit engine.
// ----------------------------------------------------------------------------
module sitbd_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sitbd_pkg::item_t         push_item,
  input  logic                     pop,
  output sitbd_pkg::item_t         head,
  output sitbd_pkg::queue_status_t status
);
  import sitbd_pkg::*;

  item_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

>>> sv/sitbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitbd_back
// Digit engine: reciprocal-multiply division per digit, digit stack, and the
// registered character output.
// ----------------------------------------------------------------------------
module sitbd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sitbd_pkg::LEN_W-1:0]         base_length,
  input  logic [sitbd_pkg::ALPHA_W-1:0]       alphabet,
  input  sitbd_pkg::queue_status_t            q_status,
  input  sitbd_pkg::item_t                    q_head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sitbd_pkg::CODE_W-1:0]        char_code,
  output logic                                last_char
);
  import sitbd_pkg::*;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_MUL  = 4'b0010,
    BK_FIX  = 4'b0100,
    BK_EMIT = 4'b1000
  } back_state_t;

  back_state_t       state;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  qest;
  logic              neg_pend;
  logic [LEN_W-1:0]  sp;
  logic [IDX_W-1:0]  stack [ALPHA_SIZE];

  logic [2*MAG_W-1:0] prod;
  logic [13:0]        qlen;
  logic [CODE_W-1:0]  rem;
  logic               rem_ge;
  logic [CODE_W-1:0]  rem_fix;
  logic [MAG_W-1:0]   qfix;
  logic [LEN_W-1:0]   sp_m1;
  logic [IDX_W-1:0]   top_digit;
  logic [CHAR_W-1:0]  top_char;
  logic               load;

  always_comb begin
    prod      = mag * recip(base_length);
    qlen      = qest[CODE_W-1:0] * {1'b0, base_length};
    rem       = mag[CODE_W-1:0] - qlen[CODE_W-1:0];
    rem_ge    = rem >= {1'b0, base_length};
    rem_fix   = rem_ge ? (rem - {1'b0, base_length}) : rem;
    qfix      = qest + MAG_W'(rem_ge);
    sp_m1     = sp - LEN_W'(1);
    top_digit = stack[sp_m1[IDX_W-1:0]];
    top_char  = alphabet[{top_digit, 3'b000} +: CHAR_W];
    load      = (state == BK_EMIT) && (!out_valid || out_ready);
  end

  assign pop = (state == BK_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      sp        <= '0;
      neg_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (pop) begin
            neg_pend <= q_head.neg;
            sp       <= '0;
            state    <= BK_MUL;
          end
        end
        BK_MUL: begin
          state <= BK_FIX;
        end
        BK_FIX: begin
          sp    <= sp + LEN_W'(1);
          state <= (qfix == '0) ? BK_EMIT : BK_MUL;
        end
        BK_EMIT: begin
          if (load) begin
            if (neg_pend) begin
              neg_pend <= 1'b0;
            end else begin
              sp <= sp_m1;
              if (sp == LEN_W'(1)) begin
                state <= BK_IDLE;
              end
            end
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mag <= q_head.mag;
    end
    if (state == BK_MUL) begin
      qest <= prod[2*MAG_W-1:MAG_W];
    end
    if (state == BK_FIX) begin
      mag                   <= qfix;
      stack[sp[IDX_W-1:0]]  <= rem_fix[IDX_W-1:0];
    end
    if (load) begin
      if (neg_pend) begin
        char_code <= CHAR_MINUS[CODE_W-1:0];
        last_char <= 1'b0;
      end else begin
        char_code <= top_char[CODE_W-1:0];
        last_char <= (sp == LEN_W'(1));
      end
    end
  end

endmodule

>>> sv/signed_integer_to_base_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_base_digits
// Converts signed 32-bit words to character strings in a configured base.
// ----------------------------------------------------------------------------
// After reset and after every register write the alphabet is checked, one
// character per cycle against all later ones; no input word is taken
// meanwhile, and with a bad alphabet words are taken and dropped. A good word
// waits in a two-entry queue, is dequeued, then passes through the shared
// divider for every digit (reciprocal multiply, then remainder fixup), and
// each character goes out through the output register. The sign character
// comes first for negatives and the last character of each number has
// last_char set.
module signed_integer_to_base_digits #(
  parameter int MAX_BASE = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sitbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sitbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sitbd_pkg::MAG_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sitbd_pkg::CODE_W-1:0]        char_code,
  output logic                                last_char
);
  import sitbd_pkg::*;

  logic [LEN_W-1:0]      base_length;
  logic [CFG_DATA_W-1:0] digits [4];
  logic [ALPHA_W-1:0]    alphabet;
  logic                  cfg_write;

  queue_status_t q_status;
  item_t         push_item;
  item_t         q_head;
  logic          push;
  logic          pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign alphabet  = {digits[3], digits[2], digits[1], digits[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= LEN_W'(10);
      digits[0]   <= 64'd3978425819141910832;
      digits[1]   <= 64'd14649;
      digits[2]   <= '0;
      digits[3]   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_LENGTH:    base_length <= cfg_data[LEN_W-1:0];
        REG_DIGITS_LOW:     digits[0]   <= cfg_data;
        REG_DIGITS_MID_LOW: digits[1]   <= cfg_data;
        REG_DIGITS_MID_HI:  digits[2]   <= cfg_data;
        REG_DIGITS_HIGH:    digits[3]   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sitbd_front #(
    .MAX_BASE (MAX_BASE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .base_length (base_length),
    .alphabet    (alphabet),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  sitbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  sitbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .base_length (base_length),
    .alphabet    (alphabet),
    .q_status    (q_status),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .last_char   (last_char)
  );

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken during alphabet check");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !in_ready)
    else $error("input taken with queue full");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == CHAR_MINUS[CODE_W-1:0]) |-> !last_char)
    else $error("sign flagged as last character");
`endif

endmodule

>>> dv/tb_signed_integer_to_base_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_integer_to_base_digits
// Self-checking bench for the signed base-digit converter. A short directed
// table covers the reset alphabet, the extremes of the value and the
// alphabet, and each kind of rejected alphabet. Random alphabets and values
// follow, with sender gaps and receiver stalls that change from phase to
// phase. Every character is checked against table text or a digit predictor.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_base_digits;
  import sitbd_pkg::*;

  localparam int MAX_BASE    = 32;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 250;
  localparam int NSTEPS      = 50;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [95:0]          NO_CHARS    = 96'd0;

  typedef enum logic [1:0] {ROW_CFG, ROW_CHECKED, ROW_TYPED} row_kind_t;
  typedef enum logic [2:0] {
    FLAW_NONE, FLAW_SHORT, FLAW_LONG, FLAW_BADCHAR, FLAW_REPEAT
  } flaw_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } char_word_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [MAG_W-1:0]      val;
    logic [95:0]           text;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [MAG_W-1:0] value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_W-1:0] char_code;
  logic last_char;

  // shadow of the configuration registers
  logic [LEN_W-1:0]      shadow_len;
  logic [CFG_DATA_W-1:0] digit_word [4];

  char_word_t pending_chars [$];
  int mismatches  = 0;
  int idle_cycles = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  step_t plan [NSTEPS] = '{
    // reset alphabet repeats '9', so nothing comes out
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd0,          NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'h7FFFFFFF,   NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'h80000000,   NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'hFFFFFFFF,   NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd9,          NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'hFFFFFFF6,   NO_CHARS},
    '{ROW_CFG,     REG_BASE_LENGTH,    64'd2, 32'd0,          NO_CHARS},
    '{ROW_CHECKED, REG_BASE_LENGTH,    64'd0, 32'h80000000,   NO_CHARS},
    '{ROW_CHECKED, REG_BASE_LENGTH,    64'd0, 32'h7FFFFFFF,   NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd5,          "101"},
    // short alphabet
    '{ROW_CFG,     REG_BASE_LENGTH,    64'd1, 32'd0,          NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd7,          NO_CHARS},
    '{ROW_CFG,     REG_BASE_LENGTH,    64'd0, 32'd0,          NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd7,          NO_CHARS},
    // long alphabet
    '{ROW_CFG,     REG_BASE_LENGTH,    64'd33, 32'd0,         NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd7,          NO_CHARS},
    '{ROW_CFG,     REG_BASE_LENGTH,    {64{1'b1}}, 32'd0,     NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd1,          NO_CHARS},
    // full 32-character alphabet, '!' is zero and '~' is 31
    '{ROW_CFG,     REG_DIGITS_LOW,     64'h2827262524232221, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_MID_LOW, 64'h3231302F2E2C2A29, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_MID_HI,  64'h3A39383736353433, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_HIGH,    64'h7E41403F3E3D3C3B, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_BASE_LENGTH,    64'd32, 32'd0,         NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd0,          "!"},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd31,         "~"},
    '{ROW_CHECKED, REG_BASE_LENGTH,    64'd0, 32'h80000000,   NO_CHARS},
    '{ROW_CHECKED, REG_BASE_LENGTH,    64'd0, 32'h7FFFFFFF,   NO_CHARS},
    // sign characters, characters out of range, repeats
    '{ROW_CFG,     REG_DIGITS_HIGH,    64'h2B41403F3E3D3C3B, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd5,          NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_HIGH,    64'h2D41403F3E3D3C3B, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd5,          NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_HIGH,    64'h7E41403F3E3D3C3B, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_LOW,     64'h2827262524232220, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd5,          NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_LOW,     64'h282726252423227F, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd5,          NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_LOW,     64'h2827262524232121, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'hFFFFFFFB,   NO_CHARS},
    // hex, bytes past the length hold junk
    '{ROW_CFG,     REG_BASE_LENGTH,    64'd16, 32'd0,         NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_LOW,     64'h3736353433323130, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_MID_LOW, 64'h4645444342413938, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_MID_HI,  64'hFF2B2D0000FFFF00, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_DIGITS_HIGH,    64'h3030303030303030, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'd255,        "FF"},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'h80000000,   "-80000000"},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'h7FFFFFFF,   "7FFFFFFF"},
    // unmapped indexes change nothing
    '{ROW_CFG,     REG_SPARE_5,        64'hA5A5A5A55A5A5A5A, 32'd0, NO_CHARS},
    '{ROW_CFG,     REG_SPARE_6,        {64{1'b1}}, 32'd0,     NO_CHARS},
    '{ROW_CFG,     REG_SPARE_7,        64'h0123456789ABCDEF, 32'd0, NO_CHARS},
    '{ROW_TYPED,   REG_BASE_LENGTH,    64'd0, 32'hFFFFFFFF,   "-1"}
  };

  signed_integer_to_base_digits #(.MAX_BASE(MAX_BASE)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_code(char_code),
    .last_char(last_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] alphabet_char(input int idx);
    return digit_word[idx / 8][(idx % 8) * 8 +: 8];
  endfunction

  function automatic bit alphabet_usable();
    logic [7:0] c;
    if (shadow_len < 2 || shadow_len > MAX_BASE) return 1'b0;
    for (int i = 0; i < shadow_len; i++) begin
      c = alphabet_char(i);
      if (c < CHAR_MIN || c > CHAR_MAX || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < shadow_len; j++)
        if (alphabet_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_digits(input logic [MAG_W-1:0] v);
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] radix;
    logic [7:0] rev [32];
    int nd;
    if (!alphabet_usable()) return;
    radix = {26'd0, shadow_len};
    mag = v[MAG_W-1] ? (~v + 32'd1) : v;
    nd = 0;
    do begin
      rev[nd] = alphabet_char(int'(mag % radix));
      nd++;
      mag = mag / radix;
    end while (mag != 0 && nd < 32);
    if (v[MAG_W-1]) pending_chars.push_back(char_word_t'{7'(CHAR_MINUS), 1'b0});
    for (int k = nd; k > 0; k--)
      pending_chars.push_back(char_word_t'{rev[k-1][6:0], k == 1});
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_LENGTH:    shadow_len = data[LEN_W-1:0];
      REG_DIGITS_LOW:     digit_word[0] = data;
      REG_DIGITS_MID_LOW: digit_word[1] = data;
      REG_DIGITS_MID_HI:  digit_word[2] = data;
      REG_DIGITS_HIGH:    digit_word[3] = data;
      default: ;
    endcase
  endtask

  task automatic send_value(input logic [MAG_W-1:0] v, input bit typed,
                            input logic [95:0] text);
    int gap;
    logic [7:0] chars [$];
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (typed) begin
      for (int b = 11; b >= 0; b--)
        if (text[8*b +: 8] != 8'd0) chars.push_back(text[8*b +: 8]);
      for (int i = 0; i < chars.size(); i++)
        pending_chars.push_back(char_word_t'{chars[i][6:0], i == chars.size() - 1});
    end else begin
      queue_digits(v);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // bad-alphabet words give no characters, so a hold-off covers them
  task automatic drain_results(input bit hold);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    if (hold) repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_alphabet(input flaw_t flaw);
    logic [7:0] pool [92];
    logic [7:0] alpha [32];
    logic [7:0] t;
    logic [CFG_DATA_W-1:0] w [4];
    int n, j, k, len, start;
    n = 0;
    for (int c = 33; c <= 126; c++)
      if (c != CHAR_PLUS && c != CHAR_MINUS) begin
        pool[n] = 8'(c);
        n++;
      end
    for (int i = 0; i < 32; i++) begin
      j = $urandom_range(91, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    case (flaw)
      FLAW_SHORT: len = $urandom_range(1, 0);
      FLAW_LONG:  len = $urandom_range(63, 33);
      default:    len = ($urandom_range(1, 0) == 0) ? $urandom_range(10, 2)
                                                     : $urandom_range(32, 2);
    endcase
    for (int i = 0; i < 32; i++)
      alpha[i] = (i < len) ? pool[i] : 8'($urandom);
    if (flaw == FLAW_BADCHAR) begin
      j = $urandom_range(len - 1, 0);
      case ($urandom_range(3, 0))
        0:       alpha[j] = 8'($urandom_range(32, 0));
        1:       alpha[j] = 8'($urandom_range(255, 127));
        2:       alpha[j] = CHAR_PLUS;
        default: alpha[j] = CHAR_MINUS;
      endcase
    end else if (flaw == FLAW_REPEAT) begin
      j = $urandom_range(len - 1, 1);
      k = $urandom_range(j - 1, 0);
      alpha[j] = alpha[k];
    end
    for (int i = 0; i < 32; i++) w[i / 8][(i % 8) * 8 +: 8] = alpha[i];
    start = $urandom_range(4, 0);
    for (int i = 0; i < 5; i++) begin
      case ((start + i) % 5)
        0:       write_reg(REG_BASE_LENGTH, {$urandom, 26'($urandom), 6'(len)});
        1:       write_reg(REG_DIGITS_LOW, w[0]);
        2:       write_reg(REG_DIGITS_MID_LOW, w[1]);
        3:       write_reg(REG_DIGITS_MID_HI, w[2]);
        default: write_reg(REG_DIGITS_HIGH, w[3]);
      endcase
    end
  endtask

  function automatic logic [MAG_W-1:0] pick_value();
    logic [MAG_W-1:0] v;
    case ($urandom_range(3, 0))
      0: v = $urandom;
      1: v = $urandom_range(100, 0);
      2: begin
        case ($urandom_range(5, 0))
          0:       v = 32'h80000000;
          1:       v = 32'h7FFFFFFF;
          2:       v = 32'h80000001;
          3:       v = 32'd1;
          4:       v = 32'd0;
          default: v = 32'hFFFFFFFF;
        endcase
      end
      default: v = $urandom >> $urandom_range(31, 0);
    endcase
    if ($urandom_range(1, 0) == 1 && v != 32'h80000000) v = ~v + 32'd1;
    return v;
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    char_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %0d last %0b", char_code, last_char));
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code || last_char !== want.last)
          report_mismatch($sformatf("char mismatch: expected %0d last %0b, got %0d last %0b",
                                    want.code, want.last, char_code, last_char));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int good_items;
    int round;
    int n;
    flaw_t flaw;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    value     = '0;
    shadow_len    = 6'd10;
    digit_word[0] = 64'h3736353433323130;
    digit_word[1] = 64'd14649;
    digit_word[2] = 64'd0;
    digit_word[3] = 64'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int s = 0; s < NSTEPS; s++) begin
      case (plan[s].kind)
        ROW_CFG: begin
          drain_results(1'b1);
          write_reg(plan[s].idx, plan[s].data);
        end
        ROW_CHECKED: send_value(plan[s].val, 1'b0, NO_CHARS);
        default:     send_value(plan[s].val, 1'b1, plan[s].text);
      endcase
    end

    good_items = 0;
    round = 0;
    while (good_items < RAND_ITEMS) begin
      case (round % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      case ($urandom_range(9, 0))
        0:       flaw = FLAW_SHORT;
        1:       flaw = FLAW_LONG;
        2:       flaw = FLAW_BADCHAR;
        3:       flaw = FLAW_REPEAT;
        default: flaw = FLAW_NONE;
      endcase
      drain_results(1'b1);
      write_alphabet(flaw);
      n = (flaw == FLAW_NONE) ? $urandom_range(40, 10) : 3;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 3) drain_results(1'b0);
        send_value(pick_value(), 1'b0, NO_CHARS);
        if (flaw == FLAW_NONE) good_items++;
      end
      round++;
    end

    drain_results(1'b1);
    if (pending_chars.size() != 0) report_mismatch("characters still expected at end");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
